FILE: rtl/byte_fifo_with_bulk_discard_top_defines.svh
// assertion macros used by bfd_core of the byte queue rtl
// depends on a clk and an active-low rst_n in the including module
`ifndef BYTE_FIFO_WITH_BULK_DISCARD_TOP_DEFINES_SVH
`define BYTE_FIFO_WITH_BULK_DISCARD_TOP_DEFINES_SVH

// condition that must hold at every edge out of reset
`define BFD_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define BFD_ASSERT_NEXT(name, trig, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

FILE: rtl/bfd_pkg.sv
// shared types and constants for the byte queue with bulk discard
// no dependencies
package bfd_pkg;

  localparam int FILL_W = 9;
  localparam int BYTE_W = 8;
  localparam int AMT_W  = 10;
  localparam int OP_W   = 3;

  localparam logic [FILL_W-1:0] CAP_RESET = 9'd256;

  // operation codes, codes five to seven do nothing
  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_PULL    = 3'd1,
    OP_PEEK    = 3'd2,
    OP_DISCARD = 3'd3,
    OP_CLEAR   = 3'd4
  } bfd_op_t;

  // one result item
  typedef struct packed {
    logic              is_full;
    logic              is_empty;
    logic [FILL_W-1:0] free_space;
    logic [FILL_W-1:0] fill_level;
    logic [FILL_W-1:0] amount_done;
    logic              accepted;
    logic              data_valid;
    logic [BYTE_W-1:0] data_out;
  } bfd_res_t;

endpackage

FILE: rtl/bfd_core.sv
// queue state, byte store and result stage of the byte queue
// depends on bfd_pkg and byte_fifo_with_bulk_discard_top_defines.svh
`include "byte_fifo_with_bulk_discard_top_defines.svh"

module bfd_core #(
  parameter int DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [bfd_pkg::FILL_W-1:0]          cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bfd_pkg::OP_W-1:0]            in_op,
  input  logic [bfd_pkg::BYTE_W-1:0]          in_data,
  input  logic [bfd_pkg::AMT_W-1:0]           in_amount,
  output logic                                res_valid,
  input  logic                                res_ready,
  output bfd_pkg::bfd_res_t                   res
);
  import bfd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = AW + 1;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_r;

  logic [FILL_W-1:0] cap_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [AW-1:0]     oldest_r, oldest_nxt;
  logic              s1_valid_r;
  bfd_res_t          res_r, res_nxt;

  logic              take;
  logic              s1_adv;
  logic [FILL_W-1:0] cap_eff;
  logic              push_ok;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [AMT_W-1:0]  mag;
  logic [FILL_W-1:0] mag_sat;

  // ring position base + off, both below twice the depth
  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] base, logic [FILL_W-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) s = s - SW'(DEPTH);
    return s[AW-1:0];
  endfunction

  // handshake toward the input and the output queue
  assign s1_adv    = s1_valid_r && res_ready;
  assign in_ready  = !s1_valid_r || res_ready;
  assign take      = in_valid && in_ready;
  assign res_valid = s1_valid_r;

  // operation decode and next state
  always_comb begin
    cap_eff    = (32'(cap_r) > DEPTH) ? FILL_W'(DEPTH) : cap_r;
    push_ok    = fill_r < cap_eff;
    wr_addr    = ring_add(oldest_r, fill_r);
    mag        = in_amount[AMT_W-1] ? (AMT_W'(0) - in_amount) : in_amount;
    mag_sat    = ({1'b0, fill_r} < mag) ? fill_r : mag[FILL_W-1:0];
    fill_nxt   = fill_r;
    oldest_nxt = oldest_r;
    wr_en      = 1'b0;
    res_nxt    = '0;
    unique case (bfd_op_t'(in_op)) inside
      OP_PUSH: begin
        if (push_ok) begin
          wr_en            = take;
          fill_nxt         = fill_r + FILL_W'(1);
          res_nxt.accepted = 1'b1;
        end
      end
      OP_PULL, OP_PEEK: begin
        if (fill_r != '0) begin
          res_nxt.data_valid = 1'b1;
          if (bfd_op_t'(in_op) == OP_PULL) begin
            oldest_nxt = ring_add(oldest_r, FILL_W'(1));
            fill_nxt   = fill_r - FILL_W'(1);
          end
        end
      end
      OP_DISCARD: begin
        fill_nxt = fill_r - mag_sat;
        if (!in_amount[AMT_W-1]) begin
          oldest_nxt = ring_add(oldest_r, mag_sat);
        end
        res_nxt.amount_done = mag_sat;
      end
      OP_CLEAR: begin
        fill_nxt = '0;
      end
      default: begin
      end
    endcase
    // empty queue restarts at the store base
    if (fill_nxt == '0) oldest_nxt = '0;
    res_nxt.fill_level = fill_nxt;
    res_nxt.free_space = (cap_eff > fill_nxt) ? (cap_eff - fill_nxt) : '0;
    res_nxt.is_empty   = (fill_nxt == '0);
    res_nxt.is_full    = (fill_nxt >= cap_eff);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= CAP_RESET;
      fill_r     <= '0;
      oldest_r   <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) cap_r <= cfg_wr_data;
      if (take) begin
        fill_r   <= fill_nxt;
        oldest_r <= oldest_nxt;
      end
      if (take) s1_valid_r <= 1'b1;
      else if (s1_adv) s1_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) res_r <= res_nxt;
  end

  // byte store, one write and one registered read per transfer
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= in_data;
    if (take) rd_r <= mem[oldest_r];
  end

  // data byte only shown when the read found one
  always_comb begin
    res          = res_r;
    res.data_out = res_r.data_valid ? rd_r : '0;
  end

  `BFD_ASSERT_ALWAYS(a_fill_in_store, 32'(fill_r) <= DEPTH, "fill count beyond store depth")
  `BFD_ASSERT_ALWAYS(a_empty_at_base, (fill_r != '0) || (oldest_r == '0), "empty queue off base")
  `BFD_ASSERT_NEXT(a_push_grows, wr_en, fill_r == $past(fill_r) + FILL_W'(1), "push lost count")
  `BFD_ASSERT_NEXT(a_result_holds, s1_valid_r && !res_ready, s1_valid_r && $stable(res_r), "result dropped")

endmodule

FILE: rtl/bfd_outq.sv
// two-entry result queue that decouples the core from the output channel
// depends on bfd_pkg
module bfd_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bfd_pkg::bfd_res_t in_res,
  output logic              out_valid,
  input  logic              out_ready,
  output bfd_pkg::bfd_res_t out_res
);
  import bfd_pkg::*;

  bfd_res_t   q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= in_res;
  end

endmodule

FILE: rtl/byte_fifo_with_bulk_discard_top.sv
// top level of the byte queue with bulk discard
// depends on bfd_pkg, bfd_core and bfd_outq
//
// Byte queue of up to DEPTH bytes with a run-time capacity: every input transfer carries one
// operation (push, pull, peek, signed discard, clear) and yields exactly one result transfer
// with the pulled byte and the queue status after the operation. One operation is taken every
// clock while in_tready is high; queue state is updated as it is taken, and the store has one
// write and one registered read port, so the result passes through the result stage holding
// the store read and then a two-entry output queue. A stalled output lets up to three results
// build up before in_tready falls.
module byte_fifo_with_bulk_discard_top #(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,   // capacity
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // data_in[7:0], discard_amount[17:8], zero pad
  input  logic [2:0]  in_tuser,      // operation[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata      // data_out, data_valid, accepted, amount_done,
                                     // fill_level, free_space, is_empty, is_full, pad
);
  import bfd_pkg::*;

  logic     core_valid;
  logic     core_ready;
  bfd_res_t core_res;
  bfd_res_t q_res;

  // queue state and result stage
  bfd_core #(
    .DEPTH(DEPTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_data    (in_tdata[7:0]),
    .in_amount  (in_tdata[17:8]),
    .res_valid  (core_valid),
    .res_ready  (core_ready),
    .res        (core_res)
  );

  // output decoupling
  bfd_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (core_valid),
    .in_ready (core_ready),
    .in_res   (core_res),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (q_res)
  );

  // result packing, first field in the low bits
  assign out_tdata = {1'b0, q_res.is_full, q_res.is_empty, q_res.free_space,
                      q_res.fill_level, q_res.amount_done, q_res.accepted,
                      q_res.data_valid, q_res.data_out};

endmodule
